// ===== sv/tshp_pkg.sv =====
package tshp_pkg;

  localparam int unsigned MaxHeaderBytes = 9;
  localparam int unsigned CountWidth     = 4;
  localparam int unsigned SizeWidth      = 64;
  localparam int unsigned GroupWidth     = 7;

  localparam logic [7:0] GroupMask     = 8'd127;
  localparam logic [7:0] LastGroupFlag = 8'd128;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TRUNCATED = 2'd1,
    STATUS_TOO_LONG  = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]           header_type;
    logic [SizeWidth-1:0] body_size;
    status_e              status;
  } out_item_t;

endpackage

// ===== sv/type_size_header_parser_top.sv =====
// Channel   Direction  Handshake                     Payload
// in        input      in_valid_i / in_ready_o       in_item_i  (in_item_t)
// out       output     out_valid_o / out_ready_i     out_item_o (out_item_t)
//
// A byte per cycle while in_ready_o is high; a result appears the cycle after a header ends.
// The parse state updates on the accepting edge, and the result register feeds the output.
// in_ready_o is high whenever the result register is empty or is being drained this cycle.
// Reset (rst_ni low, asynchronous) returns to waiting for a type byte with no result pending.
module type_size_header_parser_top
  import tshp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic                  in_size_phase_q, in_size_phase_d;
  logic [7:0]            held_type_q, held_type_d;
  logic [SizeWidth-1:0]  size_acc_q, size_acc_d;
  logic [CountWidth-1:0] group_count_q, group_count_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_item_q, out_item_d;

  logic                  accept;
  logic                  emit;
  logic [5:0]            shift_amt;
  logic [SizeWidth-1:0]  group_shifted;
  logic [SizeWidth-1:0]  acc_merged;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign shift_amt     = 6'({group_count_q, 3'b000} - {3'b000, group_count_q});
  assign group_shifted = {{(SizeWidth-GroupWidth){1'b0}},
                          in_item_i.data_byte[GroupWidth-1:0]} << shift_amt;
  assign acc_merged    = size_acc_q | group_shifted;

  always_comb begin
    in_size_phase_d = in_size_phase_q;
    held_type_d     = held_type_q;
    size_acc_d      = size_acc_q;
    group_count_d   = group_count_q;
    emit            = 1'b0;
    out_item_d      = out_item_q;
    if (accept) begin
      if (!in_size_phase_q) begin
        if (!in_item_i.stream_end) begin
          held_type_d     = in_item_i.data_byte;
          size_acc_d      = '0;
          group_count_d   = '0;
          in_size_phase_d = 1'b1;
        end
      end else begin
        out_item_d.header_type = held_type_q;
        out_item_d.body_size   = '0;
        priority if (in_item_i.stream_end) begin
          emit                = 1'b1;
          out_item_d.status   = STATUS_TRUNCATED;
        end else if ((in_item_i.data_byte & LastGroupFlag) != 8'd0) begin
          emit                 = 1'b1;
          out_item_d.body_size = acc_merged;
          out_item_d.status    = STATUS_OK;
        end else if (group_count_q >= CountWidth'(MaxHeaderBytes)) begin
          emit                = 1'b1;
          out_item_d.status   = STATUS_TOO_LONG;
        end else begin
          size_acc_d    = acc_merged;
          group_count_d = group_count_q + CountWidth'(1);
        end
        if (emit) begin
          in_size_phase_d = 1'b0;
          size_acc_d      = '0;
          group_count_d   = '0;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_size_phase_q <= 1'b0;
      held_type_q     <= '0;
      size_acc_q      <= '0;
      group_count_q   <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      in_size_phase_q <= in_size_phase_d;
      held_type_q     <= held_type_d;
      size_acc_q      <= size_acc_d;
      group_count_q   <= group_count_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_item_q <= out_item_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    group_count_q <= CountWidth'(MaxHeaderBytes))
    else $error("group count beyond header limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_size_phase_q |-> (size_acc_q == '0 && group_count_q == '0))
    else $error("size state not cleared outside a header");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (!in_size_phase_q && out_valid_o))
    else $error("result load did not end the header");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status != STATUS_OK) |-> out_item_o.body_size == '0)
    else $error("error result carries a nonzero size");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import tshp_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ItemTarget = 500;

  class header_tracker;
    bit              in_size;
    logic [7:0]      held_kind;
    logic [63:0]     size_acc;
    logic [3:0]      group_cnt;
    out_item_t       expected_headers[$];
    int unsigned     failures;

    function new();
      in_size   = 1'b0;
      held_kind = '0;
      size_acc  = '0;
      group_cnt = '0;
      failures  = 0;
    endfunction

    function void finish_header(logic [63:0] size, status_e st);
      out_item_t r;
      r.header_type = held_kind;
      r.body_size   = size;
      r.status      = st;
      expected_headers.push_back(r);
      in_size   = 1'b0;
      size_acc  = '0;
      group_cnt = '0;
    endfunction

    // Returns 1 when the item is ignored by the parser.
    function bit note_byte(in_item_t it);
      logic [7:0]  b;
      logic [63:0] grp;
      int unsigned sh;
      b = it.data_byte;
      if (!in_size) begin
        if (it.stream_end) return 1'b1;
        held_kind = b;
        size_acc  = '0;
        group_cnt = '0;
        in_size   = 1'b1;
        return 1'b0;
      end
      if (it.stream_end) begin
        finish_header('0, STATUS_TRUNCATED);
        return 1'b0;
      end
      sh  = GroupWidth * group_cnt;
      grp = 64'(b & GroupMask);
      if (sh < SizeWidth) size_acc = size_acc | (grp << sh);
      if ((b & LastGroupFlag) != 8'd0) begin
        finish_header(size_acc, STATUS_OK);
      end else if (group_cnt >= MaxHeaderBytes) begin
        finish_header('0, STATUS_TOO_LONG);
      end else begin
        group_cnt = group_cnt + 4'd1;
      end
      return 1'b0;
    endfunction

    function void check_header(out_item_t got);
      out_item_t want;
      if (expected_headers.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected item: type %h size %h status %0d",
                   got.header_type, got.body_size, got.status);
        return;
      end
      want = expected_headers.pop_front();
      if (got.header_type !== want.header_type || got.body_size !== want.body_size ||
          got.status !== want.status) begin
        failures++;
        if (failures <= 10)
          $display("item differs: expected type %h size %h status %0d, got type %h size %h status %0d",
                   want.header_type, want.body_size, want.status,
                   got.header_type, got.body_size, got.status);
      end
    endfunction

    function int unsigned pending();
      return expected_headers.size();
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  header_tracker headers = new();
  int unsigned   bytes_taken = 0;
  int unsigned   results_seen = 0;
  int unsigned   cycle_count = 0;
  bit            tx_burst = 1'b0;
  bit            rx_burst = 1'b0;

  type_size_header_parser_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, bit ended);
    in_item_t    it;
    int unsigned gap;
    it.data_byte  = b;
    it.stream_end = ended;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (!in_ready);
    if (!headers.note_byte(it)) bytes_taken++;
    @(negedge clk_i);
  endtask

  task automatic send_directed();
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h5A, 1'b0);
    repeat (9) send_byte(8'h7F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h3C, 1'b0);
    repeat (10) send_byte(8'h01, 1'b0);
  endtask

  task automatic send_random();
    int unsigned pick;
    int unsigned n;
    while (bytes_taken < ItemTarget) begin
      if ($urandom_range(0, 3) == 0) tx_burst = !tx_burst;
      pick = $urandom_range(0, 99);
      if (pick < 88) begin
        send_byte(8'($urandom), 1'b0);
        n = (pick < 80) ? $urandom_range(0, 9) : 10;
        repeat (n) send_byte(8'($urandom_range(0, 127)), 1'b0);
        if (pick < 70) send_byte(LastGroupFlag | 8'($urandom_range(0, 127)), 1'b0);
        else if (pick < 80) send_byte(8'($urandom), 1'b1);
      end else if (pick < 95) begin
        send_byte(8'($urandom), 1'b1);
      end else begin
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    int unsigned gap;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (results_seen == 40 || results_seen == 250) gap = 300;
      else gap = rx_burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      headers.check_header(out_item);
      results_seen++;
      if ($urandom_range(0, 7) == 0) rx_burst = !rx_burst;
      @(negedge clk_i);
    end
  end

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    send_directed();
    send_random();
    in_valid <= 1'b0;
    while (headers.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (headers.failures == 0 && headers.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
